FILE: sv/terrain_height_query_top_assert.svh
// ----------------------------------------------------------------------------
// terrain_height_query_top_assert
// Assertion macros for the terrain height query block.
// ----------------------------------------------------------------------------
`ifndef TERRAIN_HEIGHT_QUERY_TOP_ASSERT_SVH
`define TERRAIN_HEIGHT_QUERY_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define THQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define THQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/thq_pkg.sv
// ----------------------------------------------------------------------------
// thq_pkg
// Shared types and constants of the terrain height query block.
// ----------------------------------------------------------------------------
`default_nettype none

package thq_pkg;

  localparam int GRID_MAX_DEF = 64;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_SIZE_X = 3'd0,
    CFG_CELL_SIZE_Z = 3'd1,
    CFG_CELLS_X     = 3'd2,
    CFG_CELLS_Z     = 3'd3
  } thq_cfg_idx_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT_Z,
    ST_INIT_X,
    ST_INIT_D,
    ST_ROW,
    ST_COL,
    ST_RD_A,
    ST_RD_D,
    ST_RD_B,
    ST_RD_C,
    ST_CAP_C,
    ST_SIGN1,
    ST_SIGN2,
    ST_SIGN3,
    ST_MUL1,
    ST_DIVL1,
    ST_DIV1,
    ST_MUL2,
    ST_DIVL2,
    ST_DIV2,
    ST_SAT,
    ST_DONE
  } thq_state_t;

endpackage

`default_nettype wire

FILE: sv/terrain_height_query_top.sv
// ----------------------------------------------------------------------------
// terrain_height_query_top
// Heightfield store with an iterative triangle-plane height query.
// ----------------------------------------------------------------------------
// A write transaction stores one vertex height at the accepting edge and then
// loads the output register from ST_DONE. A query transaction runs the setup
// states ST_INIT_Z, ST_INIT_X and ST_INIT_D, then scans the grid in row order,
// visiting each row in ST_ROW and, in each row whose z band holds the point,
// each column in ST_COL (at most nx columns per such row). A hit then reads
// the four cell corners and interpolates with the shared 33x33 multiplier and
// the bit-serial 64-step divider (two divisions), then loads the output
// register. Queries that miss run the full scan. The block takes one
// transaction at a time; in_stall is high from acceptance until the result
// is loaded into the output register, and a new transaction is taken while
// the previous result still waits there.
// ----------------------------------------------------------------------------
`default_nettype none

module terrain_height_query_top
  import thq_pkg::*;
#(
  parameter int GRID_MAX = GRID_MAX_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  // configuration
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata,
  // input channel
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire                   in_operation,
  input  wire [6:0]             in_vertex_col,
  input  wire [6:0]             in_vertex_row,
  input  wire signed [31:0]     in_vertex_height,
  input  wire signed [31:0]     in_query_x,
  input  wire signed [31:0]     in_query_y,
  input  wire signed [31:0]     in_query_z,
  // result channel
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic signed [31:0]    out_height,
  output logic                  out_found
);

  localparam int STRIDE = GRID_MAX + 1;
  localparam int DEPTH  = STRIDE * STRIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(GRID_MAX + 1);
  localparam logic [AW-1:0] STRIDE_A = AW'(STRIDE);

  // configuration registers
  logic [30:0] cell_size_x_r, cell_size_z_r;
  logic [6:0]  cells_x_r, cells_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_x_r <= 31'd65536;
      cell_size_z_r <= 31'd65536;
      cells_x_r     <= 7'd64;
      cells_z_r     <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CELL_SIZE_X: cell_size_x_r <= cfg_wdata;
        CFG_CELL_SIZE_Z: cell_size_z_r <= cfg_wdata;
        CFG_CELLS_X:     cells_x_r     <= cfg_wdata[6:0];
        CFG_CELLS_Z:     cells_z_r     <= cfg_wdata[6:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Effective sizes and counts: zero means one, counts clamp to the grid.
  logic [30:0]   sx, sz;
  logic [CW-1:0] nx, nz;

  always_comb begin
    sx = (cell_size_x_r == '0) ? 31'd1 : cell_size_x_r;
    sz = (cell_size_z_r == '0) ? 31'd1 : cell_size_z_r;
    if (cells_x_r == '0)                    nx = CW'(1);
    else if (int'(cells_x_r) > GRID_MAX)    nx = CW'(GRID_MAX);
    else                                    nx = CW'(cells_x_r);
    if (cells_z_r == '0)                    nz = CW'(1);
    else if (int'(cells_z_r) > GRID_MAX)    nz = CW'(GRID_MAX);
    else                                    nz = CW'(cells_z_r);
  end

  // Sequencer
  thq_state_t state_r, state_nxt;

  logic                in_acc;
  logic                out_load;
  logic                wr_ok;

  // query and scan registers
  logic signed [31:0]  qx_r, qy_r, qz_r;
  logic signed [39:0]  dz_r, dx_r, dx0_r;
  logic [CW-1:0]       row_r, col_r;
  logic [AW-1:0]       base_r;
  logic signed [31:0]  ha_r, hb_r, hc_r, hd_r;
  logic                tri_r;
  logic signed [65:0]  p1_r;
  logic signed [63:0]  acc_r;
  logic signed [31:0]  res_h_r;
  logic                res_f_r;

  // shared multiplier
  logic signed [32:0]  mul_a, mul_b;
  logic signed [65:0]  mul_p_r;

  // shared bit-serial divider
  logic [63:0]         div_q_r;
  logic [30:0]         div_rem_r;
  logic [30:0]         div_d_r;
  logic [5:0]          div_cnt_r;
  logic                div_neg_r;
  logic [31:0]         rem_sh;
  logic                div_ge;
  logic [30:0]         rem_nx;
  logic [63:0]         q_nx;
  logic signed [63:0]  q_signed;

  // height memory
  logic signed [31:0]  mem [DEPTH];
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic signed [31:0]  mem_q_r;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_load = (state_r == ST_DONE) && (!out_valid || !out_stall);
  assign wr_ok    = (int'(in_vertex_col) <= GRID_MAX) && (int'(in_vertex_row) <= GRID_MAX);
  assign wr_addr  = AW'(in_vertex_row) * STRIDE_A + AW'(in_vertex_col);

  // scan tests
  logic signed [39:0]  sz40, sx40;
  logic                z_in, x_in, last_row, last_col;
  assign sz40     = 40'(sz);
  assign sx40     = 40'(sx);
  assign z_in     = (dz_r <= 40'sd0) && (dz_r >= -sz40);
  assign x_in     = (dx_r >= 40'sd0) && (dx_r <= sx40);
  assign last_row = (row_r == nz - CW'(1));
  assign last_col = (col_r == nx - CW'(1));

  // interpolation operands
  logic signed [32:0]  d_ha, d_hb, d_hc, d_hd, ex, ez;
  assign d_ha = 33'(ha_r);
  assign d_hb = 33'(hb_r);
  assign d_hc = 33'(hc_r);
  assign d_hd = 33'(hd_r);
  assign ex   = dx_r[32:0] - 33'(sx);
  assign ez   = dz_r[32:0] + 33'(sz);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_INIT_Z: begin mul_a = 33'(sz); mul_b = 33'(nz >> 1); end
      ST_INIT_X: begin mul_a = 33'(sx); mul_b = 33'(nx >> 1); end
      ST_SIGN1:  begin mul_a = 33'(sx); mul_b = dz_r[32:0]; end
      ST_SIGN2:  begin mul_a = 33'(sz); mul_b = dx_r[32:0]; end
      ST_MUL1: begin
        mul_a = tri_r ? (d_hd - d_ha) : (d_hc - d_hb);
        mul_b = tri_r ? ex : dx_r[32:0];
      end
      ST_MUL2: begin
        mul_a = tri_r ? (d_hd - d_hc) : (d_ha - d_hb);
        mul_b = tri_r ? ez : dz_r[32:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  // divider step: shift one dividend bit into the remainder
  assign rem_sh   = {div_rem_r, div_q_r[63]};
  assign div_ge   = (rem_sh >= {1'b0, div_d_r});
  assign rem_nx   = div_ge ? 31'(rem_sh - {1'b0, div_d_r}) : rem_sh[30:0];
  assign q_nx     = {div_q_r[62:0], div_ge};
  assign q_signed = div_neg_r ? -signed'(q_nx) : signed'(q_nx);

  // memory read address by cell corner
  always_comb begin
    unique case (state_r)
      ST_RD_D: rd_addr = base_r + AW'(1);
      ST_RD_B: rd_addr = base_r + STRIDE_A;
      ST_RD_C: rd_addr = base_r + STRIDE_A + AW'(1);
      default: rd_addr = base_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_operation == OP_WRITE && wr_ok) begin
      mem[wr_addr] <= in_vertex_height;
    end
    mem_q_r <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = (in_operation == OP_QUERY) ? ST_INIT_Z : ST_DONE;
      ST_INIT_Z: state_nxt = ST_INIT_X;
      ST_INIT_X: state_nxt = ST_INIT_D;
      ST_INIT_D: state_nxt = ST_ROW;
      ST_ROW: begin
        if (z_in)          state_nxt = ST_COL;
        else if (last_row) state_nxt = ST_DONE;
      end
      ST_COL: begin
        if (x_in)          state_nxt = ST_RD_A;
        else if (last_col) state_nxt = last_row ? ST_DONE : ST_ROW;
      end
      ST_RD_A:   state_nxt = ST_RD_D;
      ST_RD_D:   state_nxt = ST_RD_B;
      ST_RD_B:   state_nxt = ST_RD_C;
      ST_RD_C:   state_nxt = ST_CAP_C;
      ST_CAP_C:  state_nxt = ST_SIGN1;
      ST_SIGN1:  state_nxt = ST_SIGN2;
      ST_SIGN2:  state_nxt = ST_SIGN3;
      ST_SIGN3:  state_nxt = ST_MUL1;
      ST_MUL1:   state_nxt = ST_DIVL1;
      ST_DIVL1:  state_nxt = ST_DIV1;
      ST_DIV1:   if (div_cnt_r == 6'd63) state_nxt = ST_MUL2;
      ST_MUL2:   state_nxt = ST_DIVL2;
      ST_DIVL2:  state_nxt = ST_DIV2;
      ST_DIV2:   if (div_cnt_r == 6'd63) state_nxt = ST_SAT;
      ST_SAT:    state_nxt = ST_DONE;
      ST_DONE:   if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          qx_r    <= in_query_x;
          qy_r    <= in_query_y;
          qz_r    <= in_query_z;
          res_h_r <= '0;
          res_f_r <= 1'b0;
          row_r   <= '0;
        end
      end
      ST_INIT_X: dz_r  <= 40'(qz_r) - mul_p_r[39:0];
      ST_INIT_D: dx0_r <= 40'(qx_r) + mul_p_r[39:0];
      ST_ROW: begin
        if (z_in) begin
          dx_r  <= dx0_r;
          col_r <= '0;
        end else if (last_row) begin
          res_h_r <= qy_r;  // miss: hand back the caller's y
        end else begin
          row_r <= row_r + CW'(1);
          dz_r  <= dz_r + sz40;
        end
      end
      ST_COL: begin
        if (x_in) begin
          base_r <= AW'(row_r) * STRIDE_A + AW'(col_r);
        end else if (last_col) begin
          if (last_row) begin
            res_h_r <= qy_r;
          end else begin
            row_r <= row_r + CW'(1);
            dz_r  <= dz_r + sz40;
          end
        end else begin
          col_r <= col_r + CW'(1);
          dx_r  <= dx_r - sx40;
        end
      end
      ST_RD_D:  ha_r <= mem_q_r;
      ST_RD_B:  hd_r <= mem_q_r;
      ST_RD_C:  hb_r <= mem_q_r;
      ST_CAP_C: hc_r <= mem_q_r;
      ST_SIGN2: p1_r <= mul_p_r;
      ST_SIGN3: begin
        // s = sx*dz + sz*dx; upper triangle when s > 0
        tri_r <= (p1_r + mul_p_r) > 66'sd0;
        acc_r <= (p1_r + mul_p_r) > 66'sd0 ? 64'(hc_r) : 64'(ha_r);
      end
      ST_DIVL1, ST_DIVL2: begin
        div_neg_r <= mul_p_r[65];
        div_q_r   <= mul_p_r[65] ? 64'(-mul_p_r) : mul_p_r[63:0];
        div_rem_r <= '0;
        div_d_r   <= (state_r == ST_DIVL1) ? sx : sz;
        div_cnt_r <= '0;
      end
      ST_DIV1, ST_DIV2: begin
        div_q_r   <= q_nx;
        div_rem_r <= rem_nx;
        div_cnt_r <= div_cnt_r + 6'd1;
        if (div_cnt_r == 6'd63) acc_r <= acc_r + q_signed;
      end
      ST_SAT: begin
        res_f_r <= 1'b1;
        if (acc_r > 64'sd2147483647)       res_h_r <= 32'sh7FFFFFFF;
        else if (acc_r < -64'sd2147483648) res_h_r <= 32'sh80000000;
        else                               res_h_r <= acc_r[31:0];
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_height <= res_h_r;
      out_found  <= res_f_r;
    end
  end

  `include "terrain_height_query_top_assert.svh"

  `THQ_ASSERT_NEXT(a_query_starts, in_acc && in_operation == OP_QUERY, state_r == ST_INIT_Z)
  `THQ_ASSERT_NEXT(a_write_done, in_acc && in_operation == OP_WRITE, state_r == ST_DONE)
  `THQ_ASSERT_NOW(a_scan_bounds, state_r == ST_COL, row_r < nz && col_r < nx)
  `THQ_ASSERT_NEXT(a_load_valid, out_load, out_valid)
  `THQ_ASSERT_NOW(a_no_drop, out_valid && out_stall && state_r == ST_DONE, !out_load)

endmodule

`default_nettype wire
